@@ rtl/core/lkv_pkg.sv @@
// Package for the LRU key/value cache: sizes, request and result structs,
// cell command and chain link types, and the control state encoding.
// Standalone; used by lkv_cell and lru_key_value_cache_unit.
package lkv_pkg;

  // Built number of entries and derived widths.
  localparam int MAX_ENTRIES = 16;
  localparam int RANK_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int OCC_W       = $clog2(MAX_ENTRIES + 1);
  localparam int CAP_W       = 5;
  localparam int CMP_W       = (OCC_W > CAP_W) ? OCC_W : CAP_W;
  localparam int KEY_W       = 32;
  localparam int VAL_W       = 32;

  // Request codes.
  localparam logic MODE_GET = 1'b0;
  localparam logic MODE_PUT = 1'b1;

  // One request: a get or a put.
  typedef struct packed {
    logic                    mode;
    logic [KEY_W-1:0]        key;
    logic signed [VAL_W-1:0] value;
  } lkv_req_t;

  // One result.
  typedef struct packed {
    logic                    found;
    logic signed [VAL_W-1:0] read_value;
    logic                    evicted;
  } lkv_rsp_t;

  // Operation broadcast to every cell.
  typedef enum logic [1:0] {
    CELL_IDLE,
    CELL_TOUCH,
    CELL_INSERT
  } lkv_cell_op_t;

  // Command broadcast to the row of cells.
  typedef struct packed {
    lkv_cell_op_t            op;
    logic [KEY_W-1:0]        key;
    logic signed [VAL_W-1:0] value;
    logic                    write;
    logic [RANK_W-1:0]       hit_rank;
    logic                    do_evict;
    logic [RANK_W-1:0]       evict_rank;
  } lkv_cmd_t;

  // Link passed from one cell to the next along the row.
  typedef struct packed {
    logic                    hit;
    logic [RANK_W-1:0]       rank;
    logic signed [VAL_W-1:0] value;
    logic                    free;
  } lkv_link_t;

  // Control states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE
  } lkv_state_t;

endpackage

@@ rtl/core/lkv_cell.sv @@
// One cache entry: key, value, valid bit and recency rank, with the
// compare, free-slot and rank update logic that chains to its neighbor.
// Depends on lkv_pkg.
module lkv_cell (
  input  logic              clk,
  input  logic              rst,
  input  lkv_pkg::lkv_cmd_t cmd,
  input  lkv_pkg::lkv_link_t link_in,
  output lkv_pkg::lkv_link_t link_out
);
  import lkv_pkg::*;

  logic [KEY_W-1:0]        key;
  logic signed [VAL_W-1:0] value;
  logic                    valid;
  logic [RANK_W-1:0]       rank;

  logic hit_here;
  logic evict_here;
  logic valid_eff;
  logic take;

  // Key compare and the victim and free-slot decisions for this entry.
  always_comb begin
    hit_here   = valid && (key == cmd.key);
    evict_here = (cmd.op == CELL_INSERT) && cmd.do_evict && valid &&
                 (rank == cmd.evict_rank);
    valid_eff  = valid && !evict_here;
    take       = (cmd.op == CELL_INSERT) && !link_in.free && !valid_eff;
  end

  // Pass the hit data down the row and mark whether a free slot was seen.
  always_comb begin
    link_out.hit   = link_in.hit | hit_here;
    link_out.rank  = hit_here ? rank  : link_in.rank;
    link_out.value = hit_here ? value : link_in.value;
    link_out.free  = link_in.free | !valid_eff;
  end

  // Valid bit and rank are control state and are cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      rank  <= '0;
    end else begin
      case (cmd.op)
        CELL_TOUCH: begin
          if (hit_here) begin
            rank <= '0;
          end else if (valid && (rank < cmd.hit_rank)) begin
            rank <= rank + RANK_W'(1);
          end
        end
        CELL_INSERT: begin
          if (take) begin
            valid <= 1'b1;
            rank  <= '0;
          end else if (valid_eff) begin
            rank <= rank + RANK_W'(1);
          end else if (evict_here) begin
            valid <= 1'b0;
            rank  <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Payload of the entry needs no reset.
  always_ff @(posedge clk) begin
    if (cmd.op == CELL_TOUCH && hit_here && cmd.write) begin
      value <= cmd.value;
    end else if (take) begin
      key   <= cmd.key;
      value <= cmd.value;
    end
  end

endmodule

@@ rtl/core/lru_key_value_cache_unit.sv @@
// LRU key/value cache, fully associative, built as a row of entry cells.
// Each request passes through the lookup and then the update state, both in
// the shared cell row; the result strobe is registered at the end of update.
// Busy is high in lookup and update, so a new request is taken only when idle.
// Reset: synchronous; empties the cache and sets capacity to its maximum.
// The done strobe is high for one cycle only, as the receiver cannot stall.
module lru_key_value_cache_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  lkv_pkg::lkv_req_t             request,
  output logic                          done,
  output lkv_pkg::lkv_rsp_t             result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lkv_pkg::CAP_W-1:0]     cfg_data
);
  import lkv_pkg::*;

  lkv_state_t state;
  lkv_state_t state_next;

  lkv_req_t          req;
  logic [CAP_W-1:0]  capacity;
  logic [OCC_W-1:0]  occupancy;
  logic [OCC_W-1:0]  occ_less;
  logic [CMP_W-1:0]  cap_act;

  logic                    hit;
  logic [RANK_W-1:0]       hit_rank;
  logic signed [VAL_W-1:0] hit_value;
  logic                    evict;

  lkv_cmd_t  cmd;
  lkv_link_t links [MAX_ENTRIES+1];

  assign cfg_ready = 1'b1;

  // Capacity register; zero acts as one and large values saturate.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_W'(MAX_ENTRIES);
    end else if (cfg_valid && cfg_ready) begin
      capacity <= cfg_data;
    end
  end

  always_comb begin
    if (capacity == '0) begin
      cap_act = CMP_W'(1);
    end else if (CMP_W'(capacity) > CMP_W'(MAX_ENTRIES)) begin
      cap_act = CMP_W'(MAX_ENTRIES);
    end else begin
      cap_act = CMP_W'(capacity);
    end
    occ_less = occupancy - OCC_W'(1);
  end

  // Next state.
  always_comb begin
    case (state)
      ST_IDLE:   state_next = start ? ST_LOOKUP : ST_IDLE;
      ST_LOOKUP: state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control outputs: busy and the command sent along the cell row.
  always_comb begin
    busy         = (state != ST_IDLE);
    cmd.op       = CELL_IDLE;
    cmd.key      = req.key;
    cmd.value    = req.value;
    cmd.write    = (req.mode == MODE_PUT);
    cmd.hit_rank = hit_rank;
    cmd.do_evict = evict;
    cmd.evict_rank = occ_less[RANK_W-1:0];
    case (state)
      ST_UPDATE: begin
        if (hit) begin
          cmd.op = CELL_TOUCH;
        end else if (req.mode == MODE_PUT) begin
          cmd.op = CELL_INSERT;
        end
      end
      default: begin
        cmd.op = CELL_IDLE;
      end
    endcase
  end

  // Request holding register.
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req <= request;
    end
  end

  // Row of entry cells; the chain starts with no hit and no free slot seen.
  assign links[0] = '0;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    lkv_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cmd      (cmd),
      .link_in  (links[i]),
      .link_out (links[i+1])
    );
  end

  // Capture the lookup outcome at the end of the lookup cycle.
  always_ff @(posedge clk) begin
    if (state == ST_LOOKUP) begin
      hit       <= links[MAX_ENTRIES].hit;
      hit_rank  <= links[MAX_ENTRIES].rank;
      hit_value <= links[MAX_ENTRIES].value;
      evict     <= (req.mode == MODE_PUT) && !links[MAX_ENTRIES].hit &&
                   (CMP_W'(occupancy) >= cap_act);
    end
  end

  // Occupancy grows only on an insert that does not evict.
  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
    end else if (state == ST_UPDATE && !hit && req.mode == MODE_PUT && !evict) begin
      occupancy <= occupancy + OCC_W'(1);
    end
  end

  // Result register and its one-cycle strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == ST_UPDATE);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_UPDATE) begin
      result.found      <= hit;
      result.read_value <= (hit && req.mode == MODE_GET) ? hit_value : '0;
      result.evicted    <= evict;
    end
  end

endmodule

@@ bench/lkv_cache_checker.sv @@
`timescale 1ns / 100ps
// Checker for the LRU key/value cache: watches the request, result and capacity channels,
// predicts each result and compares it field by field. Depends on lkv_pkg.
module lkv_cache_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          busy,
  input  lkv_pkg::lkv_req_t             request,
  input  logic                          done,
  input  lkv_pkg::lkv_rsp_t             result,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [lkv_pkg::CAP_W-1:0]     cfg_data,
  output int                            mismatch_count,
  output int                            outstanding
);
  import lkv_pkg::*;

  // Predicted contents of the cache.
  logic [KEY_W-1:0]        slot_key   [MAX_ENTRIES];
  logic signed [VAL_W-1:0] slot_value [MAX_ENTRIES];
  bit                      slot_live  [MAX_ENTRIES];
  int                      slot_age   [MAX_ENTRIES];
  int                      live_count;
  logic [CAP_W-1:0]        capacity;

  // Results still owed by the block, oldest first.
  lkv_rsp_t                awaited_results [$];
  lkv_rsp_t                oldest;

  initial mismatch_count = 0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    mismatch_count++;
    $display("%0t ns: %s mismatch: got %h, expected %h", $time, what, got, want);
  endtask

  function automatic void empty_cache();
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      slot_live[i] = 1'b0;
      slot_age[i]  = 0;
    end
    live_count = 0;
    capacity   = 5'd16;
  endfunction

  // Slot s becomes the most recent; entries younger than its old age grow one older.
  function automatic void make_newest(input int s, input int old_age);
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (i != s && slot_live[i] && slot_age[i] < old_age) slot_age[i]++;
    end
    slot_age[s] = 0;
  endfunction

  // Applies one request to the predicted cache and returns the result it causes.
  function automatic lkv_rsp_t cache_access(input lkv_req_t req);
    lkv_rsp_t rsp;
    int       slot;
    int       victim;
    int       limit;
    rsp  = '0;
    slot = -1;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (slot < 0 && slot_live[i] && slot_key[i] == req.key) slot = i;
    end
    if (req.mode == MODE_GET) begin
      if (slot >= 0) begin
        rsp.found      = 1'b1;
        rsp.read_value = slot_value[slot];
        make_newest(slot, slot_age[slot]);
      end
    end else if (slot >= 0) begin
      rsp.found        = 1'b1;
      slot_value[slot] = req.value;
      make_newest(slot, slot_age[slot]);
    end else begin
      // A zero capacity acts as one; anything above the built size saturates.
      limit = (capacity == 0) ? 1 : ((capacity > MAX_ENTRIES) ? MAX_ENTRIES : int'(capacity));
      if (live_count >= limit) begin
        victim = -1;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
          if (slot_live[i] && (victim < 0 || slot_age[i] > slot_age[victim])) victim = i;
        end
        if (victim >= 0) begin
          slot_live[victim] = 1'b0;
          slot_age[victim]  = 0;
          live_count--;
          rsp.evicted = 1'b1;
        end
      end
      // The new key takes the lowest free slot.
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (slot < 0 && !slot_live[i]) slot = i;
      end
      if (slot >= 0) begin
        slot_live[slot]  = 1'b1;
        slot_key[slot]   = req.key;
        slot_value[slot] = req.value;
        live_count++;
        make_newest(slot, live_count);
      end
    end
    return rsp;
  endfunction

  // Results are retired before a new request is predicted, as a result never belongs
  // to the request accepted at the same edge.
  always @(posedge clk) begin
    if (rst) begin
      empty_cache();
      awaited_results.delete();
      outstanding <= 0;
    end else begin
      if (done) begin
        if (awaited_results.size() == 0) begin
          report("unexpected result", result.read_value, 32'h0);
        end else begin
          oldest = awaited_results.pop_front();
          if (result.found !== oldest.found) begin
            report("found", result.found, oldest.found);
          end
          if (result.read_value !== oldest.read_value) begin
            report("read_value", result.read_value, oldest.read_value);
          end
          if (result.evicted !== oldest.evicted) begin
            report("evicted", result.evicted, oldest.evicted);
          end
        end
      end
      if (cfg_valid && cfg_ready) capacity = cfg_data;
      if (start && !busy) awaited_results = {awaited_results, cache_access(request)};
      outstanding <= awaited_results.size();
    end
  end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// Top of the LRU key/value cache bench: clock, reset, directed and random requests,
// capacity changes, watchdog and verdict. Depends on lkv_pkg and lkv_cache_checker.
module tb_top;
  import lkv_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS    = 63;
  localparam int POOL_SIZE      = 24;
  localparam int PHASES         = 10;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  lkv_req_t            request;
  logic                done;
  lkv_rsp_t            result;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CAP_W-1:0]    cfg_data;
  int                  mismatch_count;
  int                  outstanding;
  int                  stall_cycles;
  logic [KEY_W-1:0]    key_pool [POOL_SIZE];
  logic [CAP_W-1:0]    phase_caps [PHASES] = '{5'd16, 5'd3, 5'd31, 5'd1, 5'd8,
                                               5'd0, 5'd17, 5'd12, 5'd2, 5'd16};

  lru_key_value_cache_unit uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .request   (request),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  lkv_cache_checker cache_check (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .request        (request),
    .done           (done),
    .result         (result),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Presents one request and returns at the edge that accepts it, leaving start high.
  task automatic issue(input logic m, input logic [KEY_W-1:0] k, input logic [VAL_W-1:0] v);
    start   <= 1'b1;
    request <= {m, k, v};
    do @(posedge clk); while (busy);
  endtask

  task automatic pause(input int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Holds off new requests until every predicted result has come back.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] c);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= c;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Random requests over a key pool sized to the capacity, so hits and evictions both occur.
  task automatic run_phase(input logic [CAP_W-1:0] c, input int idle_pct, input bit hold_mid);
    int               active;
    int               span;
    logic [KEY_W-1:0] k;
    active = (c == 0) ? 1 : ((c > MAX_ENTRIES) ? MAX_ENTRIES : int'(c));
    span   = (2 * active + 2 > POOL_SIZE) ? POOL_SIZE : 2 * active + 2;
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      if ($urandom_range(0, 99) < idle_pct) pause($urandom_range(1, 5));
      k = ($urandom_range(0, 9) == 0) ? $urandom : key_pool[$urandom_range(0, span - 1)];
      issue($urandom_range(0, 1) ? MODE_PUT : MODE_GET, k, $urandom);
      if (hold_mid && n == PHASE_ITEMS / 2) drain();
    end
  endtask

  // Watchdog: ends the run when no request, capacity write or result is seen for too long.
  initial begin
    stall_cycles = 0;
    while (stall_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || done || (cfg_valid && cfg_ready)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    rst       = 1'b1;
    start     = 1'b0;
    request   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Empty cache, extreme keys and values, hits and an update that stores minus one.
    issue(MODE_GET, 32'h0000_0000, 32'h1234_5678);
    issue(MODE_PUT, 32'h0000_0000, 32'h7FFF_FFFF);
    issue(MODE_PUT, 32'hFFFF_FFFF, 32'h8000_0000);
    issue(MODE_GET, 32'h0000_0000, 32'h0);
    issue(MODE_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue(MODE_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
    issue(MODE_GET, 32'h0000_0000, 32'h0);
    issue(MODE_GET, 32'h0001_2345, 32'h0);

    // A full cache of two evicts the least recent entry; a put on a present key never does.
    set_capacity(5'd2);
    issue(MODE_PUT, 32'h0000_0005, 32'h0000_0055);
    issue(MODE_GET, 32'hFFFF_FFFF, 32'h0);
    issue(MODE_PUT, 32'h0000_0000, 32'h0000_0001);
    issue(MODE_PUT, 32'h0000_0006, 32'h0000_0066);

    // Capacity lowered below the number of entries held.
    set_capacity(5'd1);
    issue(MODE_PUT, 32'h0000_0007, 32'h0000_0077);
    issue(MODE_PUT, 32'h0000_0008, 32'h0000_0088);
    issue(MODE_GET, 32'h0000_0000, 32'h0);

    // A zero capacity behaves as one.
    set_capacity(5'd0);
    issue(MODE_PUT, 32'h0000_0009, 32'h0000_0099);
    issue(MODE_PUT, 32'h0000_000A, 32'hAAAA_AAAA);

    // A capacity above the built size saturates.
    set_capacity(5'd31);
    issue(MODE_PUT, 32'h0000_000B, 32'h5555_5555);
    issue(MODE_GET, 32'h0000_000A, 32'h0);

    // Random phases; one runs without idling and one holds off mid-phase.
    for (int p = 0; p < PHASES; p++) begin
      set_capacity(phase_caps[p]);
      run_phase(phase_caps[p], (p == 3) ? 0 : 8, p == 5);
    end

    drain();
    repeat (6) @(posedge clk);
    if (mismatch_count == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

endmodule
